/* sv/rpqm_pkg.sv */
// Shared types, field layout, operation codes and register indexes for the rate PID mixer.
package rpqm_pkg;

	localparam int COEF_W_DEF = 21;
	localparam int DATA_W_DEF = 32;

	localparam int ANG_W  = 16;
	localparam int REF_W  = 24;
	localparam int THR_W  = 24;
	localparam int SPD_W  = 32;
	localparam int IN_W   = 3 * ANG_W + 3 * REF_W + THR_W;
	localparam int OUT_W  = 4 * SPD_W;

	localparam int COEF_REG_W = 63;
	localparam int ISP_W      = 16;
	localparam int GAIN_W     = 16;
	localparam int LIM_W      = 32;
	localparam int CFG_W      = 63;
	localparam int CFG_IDX_W  = 3;

	localparam int MUL_W   = 25;
	localparam int CHUNK_W = 24;
	localparam int MIX_W   = 48;

	localparam logic [CFG_IDX_W-1:0] REG_PITCH_COEF = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROLL_COEF  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_YAW_COEF   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ISP        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LIM_HI     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_LIM_LO     = 3'd6;

	localparam logic [3:0] OP_NOP  = 4'd0;
	localparam logic [3:0] OP_LOAD = 4'd1;
	localparam logic [3:0] OP_RATE = 4'd2;
	localparam logic [3:0] OP_ERR  = 4'd3;
	localparam logic [3:0] OP_COEF = 4'd4;
	localparam logic [3:0] OP_FIN  = 4'd5;
	localparam logic [3:0] OP_MSUM = 4'd6;
	localparam logic [3:0] OP_MMUL = 4'd7;
	localparam logic [3:0] OP_MFIN = 4'd8;
	localparam logic [3:0] OP_OUT  = 4'd9;

	localparam logic [1:0] AX_ROLL  = 2'd0;
	localparam logic [1:0] AX_PITCH = 2'd1;
	localparam logic [1:0] AX_YAW   = 2'd2;

	localparam logic [1:0] ROT_FRONT = 2'd0;
	localparam logic [1:0] ROT_RIGHT = 2'd1;
	localparam logic [1:0] ROT_BACK  = 2'd2;
	localparam logic [1:0] ROT_LEFT  = 2'd3;

	typedef struct packed {
		logic [3:0] op;
		logic [1:0] axis;
		logic [1:0] k;
		logic       j;
		logic [1:0] rotor;
	} cmd_t;

	typedef struct packed {
		logic [COEF_REG_W-1:0] pitch_coef;
		logic [COEF_REG_W-1:0] roll_coef;
		logic [COEF_REG_W-1:0] yaw_coef;
		logic [ISP_W-1:0]      isp;
		logic [GAIN_W-1:0]     gain;
		logic [LIM_W-1:0]      lim_hi;
		logic [LIM_W-1:0]      lim_lo;
	} cfg_t;

endpackage

/* sv/rate_pid_quad_mixer_core.sv */
// Top level: rate PID on three axes with quad-X mixer, one result per input transfer.
// The three PID axes are processed first, then the four rotors, then the output register
// is loaded; all of this runs on one shared 25x25 multiplier.
// A new transfer is accepted only once the previous one is processed; a pending result
// waits in its output register while the next item is processed.
// Reset: asynchronous, active low; clears history, PID outputs and loads register defaults.
module rate_pid_quad_mixer_core import rpqm_pkg::*; #(
	parameter int COEF_WIDTH = COEF_W_DEF,
	parameter int DATA_WIDTH = DATA_W_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// roll_angle, pitch_angle, yaw_angle, roll_rate_ref, pitch_rate_ref,
	// yaw_rate_ref, base_thrust
	input  logic [IN_W-1:0]      s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// rotor_front_speed, rotor_right_speed, rotor_back_speed, rotor_left_speed
	output logic [OUT_W-1:0]     m_tdata,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_data
);

	cfg_t cfg;
	cmd_t cmd;

	rpqm_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	rpqm_ctrl #(.DW(DATA_WIDTH)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	rpqm_dp #(.CW(COEF_WIDTH), .DW(DATA_WIDTH)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cfg      (cfg),
		.in_data  (s_tdata),
		.out_data (m_tdata)
	);

endmodule

/* sv/rpqm_cfg.sv */
// Configuration register bank.
module rpqm_cfg import rpqm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pitch_coef <= '0;
			cfg_q.roll_coef  <= '0;
			cfg_q.yaw_coef   <= '0;
			cfg_q.isp        <= ISP_W'(100);
			cfg_q.gain       <= GAIN_W'(256);
			cfg_q.lim_hi     <= '0;
			cfg_q.lim_lo     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_PITCH_COEF: cfg_q.pitch_coef <= cfg_data;
				REG_ROLL_COEF:  cfg_q.roll_coef  <= cfg_data;
				REG_YAW_COEF:   cfg_q.yaw_coef   <= cfg_data;
				REG_ISP:        cfg_q.isp        <= cfg_data[ISP_W-1:0];
				REG_GAIN:       cfg_q.gain       <= cfg_data[GAIN_W-1:0];
				REG_LIM_HI:     cfg_q.lim_hi     <= cfg_data[LIM_W-1:0];
				REG_LIM_LO:     cfg_q.lim_lo     <= cfg_data[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* sv/rpqm_dp.sv */
// Datapath: input and state registers, shared multiplier, accumulator and mixer.
module rpqm_dp import rpqm_pkg::*; #(
	parameter int CW = COEF_W_DEF,
	parameter int DW = DATA_W_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	input  cfg_t             cfg,
	input  logic [IN_W-1:0]  in_data,
	output logic [OUT_W-1:0] out_data
);

	localparam int NCH = (DW + CHUNK_W - 1) / CHUNK_W;
	localparam int EXW = NCH * CHUNK_W;
	localparam int EW  = (DW > 36 ? DW : 36) + 1;
	localparam int AW  = (CW + DW + 3 > 66) ? CW + DW + 3 : 66;
	localparam int RW  = AW - 8;
	localparam int SW  = (DW > 25 ? DW : 25) + 3;
	localparam int SWX = (SW > MIX_W) ? SW : MIX_W;

	localparam logic signed [EW-1:0]  EMAX = {{(EW-DW+1){1'b0}}, {(DW-1){1'b1}}};
	localparam logic signed [EW-1:0]  EMIN = ~EMAX;
	localparam logic signed [RW-1:0]  RMAX = {{(RW-DW+1){1'b0}}, {(DW-1){1'b1}}};
	localparam logic signed [RW-1:0]  RMIN = ~RMAX;
	localparam logic signed [AW-1:0]  OMAX = {{(AW-SPD_W+1){1'b0}}, {(SPD_W-1){1'b1}}};
	localparam logic signed [AW-1:0]  OMIN = ~OMAX;
	localparam logic signed [SWX-1:0] BND  = {{(SWX-47){1'b0}}, 1'b1, {46{1'b0}}};
	localparam logic signed [SWX-1:0] NBND = -BND;
	localparam logic signed [AW-1:0]  PID_RND = AW'(128);
	localparam logic signed [AW-1:0]  MIX_RND = AW'(256);

	logic signed [ANG_W-1:0]   ang_q [3];
	logic signed [REF_W-1:0]   ref_q [3];
	logic        [THR_W-1:0]   thr_q;
	logic signed [ANG_W-1:0]   prev_q [3];
	logic signed [DW-1:0]      eh1_q [3];
	logic signed [DW-1:0]      eh2_q [3];
	logic signed [DW-1:0]      u_q [3];
	logic signed [DW-1:0]      e0_q;
	logic signed [MIX_W-1:0]   s_q;
	logic signed [AW-1:0]      acc_q;
	logic signed [SPD_W-1:0]   rot_q [4];
	logic        [OUT_W-1:0]   out_q;
	logic signed [2*MUL_W-1:0] prod_s1;
	logic                      acc_en_s1;
	logic                      sh_s1;

	logic signed [MUL_W-1:0]   mul_a;
	logic signed [MUL_W-1:0]   mul_b;
	logic signed [2*MUL_W-1:0] prod;
	logic signed [AW-1:0]      addend;
	logic signed [DW-1:0]      e0_new;
	logic signed [DW-1:0]      u_new;
	logic signed [MIX_W-1:0]   s_new;
	logic signed [SPD_W-1:0]   spd_new;
	logic signed [AW-1:0]      acc_init;

	always_comb begin
		logic signed [ANG_W:0]      diff;
		logic        [COEF_REG_W-1:0] creg;
		logic signed [CW-1:0]       q;
		logic signed [DW-1:0]       esel;
		logic signed [EXW-1:0]      ex;
		logic        [CHUNK_W-1:0]  ch;
		logic signed [EW-1:0]       rt;
		logic signed [EW-1:0]       dd;
		logic signed [RW-1:0]       raw;
		logic signed [RW-1:0]       lhi;
		logic signed [RW-1:0]       llo;
		logic signed [SWX-1:0]      sp;
		logic signed [SWX-1:0]      sr;
		logic signed [SWX-1:0]      sy;
		logic signed [SWX-1:0]      st;
		logic signed [SWX-1:0]      sm;
		logic signed [AW-1:0]       v;

		diff = {ang_q[cmd.axis][ANG_W-1], ang_q[cmd.axis]}
			- {prev_q[cmd.axis][ANG_W-1], prev_q[cmd.axis]};

		unique case (cmd.axis)
			AX_ROLL:  creg = cfg.roll_coef;
			AX_PITCH: creg = cfg.pitch_coef;
			default:  creg = cfg.yaw_coef;
		endcase
		q = $signed(creg[cmd.k*CW +: CW]);

		unique case (cmd.k)
			2'd0:    esel = e0_q;
			2'd1:    esel = eh1_q[cmd.axis];
			default: esel = eh2_q[cmd.axis];
		endcase
		ex = EXW'(esel);
		ch = ex[cmd.j*CHUNK_W +: CHUNK_W];

		unique case (cmd.op)
			OP_RATE: begin
				mul_a = MUL_W'(diff);
				mul_b = MUL_W'({1'b0, cfg.isp});
			end
			OP_COEF: begin
				mul_a = MUL_W'(q);
				if (int'(cmd.j) == NCH - 1)
					mul_b = {ch[CHUNK_W-1], ch};
				else
					mul_b = {1'b0, ch};
			end
			OP_MMUL: begin
				mul_a = MUL_W'({1'b0, cfg.gain});
				if (cmd.j)
					mul_b = {s_q[MIX_W-1], s_q[MIX_W-1:CHUNK_W]};
				else
					mul_b = {1'b0, s_q[CHUNK_W-1:0]};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		prod = mul_a * mul_b;

		addend = sh_s1 ? (AW'(prod_s1) <<< CHUNK_W) : AW'(prod_s1);

		// measured rate is doubled product of angle step and sample rate
		rt = EW'($signed(prod_s1[2*(ANG_W+1)-1:0])) <<< 1;
		dd = EW'(ref_q[cmd.axis]) - rt;
		if (dd > EMAX)
			e0_new = EMAX[DW-1:0];
		else if (dd < EMIN)
			e0_new = EMIN[DW-1:0];
		else
			e0_new = dd[DW-1:0];
		acc_init = (AW'(u_q[cmd.axis]) <<< 8) + PID_RND;

		// when lim_hi is nonzero: upper bound first, lower bound wins
		raw = RW'(acc_q >>> 8);
		lhi = RW'($signed(cfg.lim_hi));
		llo = RW'($signed(cfg.lim_lo));
		if (cfg.lim_hi != '0) begin
			if (raw > lhi)
				raw = lhi;
			if (raw < llo)
				raw = llo;
		end
		if (raw > RMAX)
			u_new = RMAX[DW-1:0];
		else if (raw < RMIN)
			u_new = RMIN[DW-1:0];
		else
			u_new = raw[DW-1:0];

		sp = SWX'(u_q[AX_PITCH]);
		sr = SWX'(u_q[AX_ROLL]);
		sy = SWX'(u_q[AX_YAW]) <<< 1;
		st = SWX'({1'b0, thr_q, 1'b0});
		unique case (cmd.rotor)
			ROT_FRONT: sm = st - sp - sr - sy;
			ROT_RIGHT: sm = st + sp - sr + sy;
			ROT_BACK:  sm = st + sp + sr - sy;
			default:   sm = st - sp + sr + sy;
		endcase
		if (sm > BND)
			sm = BND;
		if (sm < NBND)
			sm = NBND;
		s_new = sm[MIX_W-1:0];

		v = acc_q >>> 9;
		if (v > OMAX)
			spd_new = OMAX[SPD_W-1:0];
		else if (v < OMIN)
			spd_new = OMIN[SPD_W-1:0];
		else
			spd_new = v[SPD_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				prev_q[i] <= '0;
				eh1_q[i]  <= '0;
				eh2_q[i]  <= '0;
				u_q[i]    <= '0;
			end
			acc_en_s1 <= 1'b0;
		end else begin
			acc_en_s1 <= (cmd.op == OP_COEF) || (cmd.op == OP_MMUL);
			if (cmd.op == OP_FIN) begin
				prev_q[cmd.axis] <= ang_q[cmd.axis];
				eh2_q[cmd.axis]  <= eh1_q[cmd.axis];
				eh1_q[cmd.axis]  <= e0_q;
				u_q[cmd.axis]    <= u_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod;
		sh_s1   <= cmd.j;
		unique case (cmd.op)
			OP_LOAD: begin
				ang_q[0] <= in_data[0 +: ANG_W];
				ang_q[1] <= in_data[ANG_W +: ANG_W];
				ang_q[2] <= in_data[2*ANG_W +: ANG_W];
				ref_q[0] <= in_data[3*ANG_W +: REF_W];
				ref_q[1] <= in_data[3*ANG_W+REF_W +: REF_W];
				ref_q[2] <= in_data[3*ANG_W+2*REF_W +: REF_W];
				thr_q    <= in_data[3*ANG_W+3*REF_W +: THR_W];
			end
			OP_ERR: begin
				e0_q  <= e0_new;
				acc_q <= acc_init;
			end
			OP_MSUM: begin
				s_q   <= s_new;
				acc_q <= MIX_RND;
			end
			OP_MFIN: rot_q[cmd.rotor] <= spd_new;
			OP_OUT:  out_q <= {rot_q[3], rot_q[2], rot_q[1], rot_q[0]};
			default: ;
		endcase
		if (acc_en_s1)
			acc_q <= acc_q + addend;
	end

	assign out_data = out_q;

endmodule

/* sv/rpqm_ctrl.sv */
// Sequencer: steps the datapath through three PID axes and four rotors per transfer.
module rpqm_ctrl import rpqm_pkg::*; #(
	parameter int DW = DATA_W_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	output logic m_tvalid,
	input  logic m_tready,
	output cmd_t cmd
);

	localparam int NCH = (DW + CHUNK_W - 1) / CHUNK_W;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_RATE   = 4'd1;
	localparam logic [3:0] ST_ERR    = 4'd2;
	localparam logic [3:0] ST_COEF   = 4'd3;
	localparam logic [3:0] ST_DRAIN  = 4'd4;
	localparam logic [3:0] ST_FIN    = 4'd5;
	localparam logic [3:0] ST_MSUM   = 4'd6;
	localparam logic [3:0] ST_MMUL   = 4'd7;
	localparam logic [3:0] ST_MDRAIN = 4'd8;
	localparam logic [3:0] ST_MFIN   = 4'd9;
	localparam logic [3:0] ST_DONE   = 4'd10;

	logic [3:0] state_q;
	logic [1:0] axis_q;
	logic [1:0] k_q;
	logic       j_q;
	logic [1:0] rotor_q;
	logic       m_tvalid_q;
	logic       out_free;
	logic       done_fire;

	assign out_free  = !m_tvalid_q || m_tready;
	assign done_fire = (state_q == ST_DONE) && out_free;
	assign s_tready  = (state_q == ST_IDLE);
	assign m_tvalid  = m_tvalid_q;

	always_comb begin
		cmd.axis  = axis_q;
		cmd.k     = k_q;
		cmd.j     = j_q;
		cmd.rotor = rotor_q;
		unique case (state_q)
			ST_IDLE:  cmd.op = s_tvalid ? OP_LOAD : OP_NOP;
			ST_RATE:  cmd.op = OP_RATE;
			ST_ERR:   cmd.op = OP_ERR;
			ST_COEF:  cmd.op = OP_COEF;
			ST_FIN:   cmd.op = OP_FIN;
			ST_MSUM:  cmd.op = OP_MSUM;
			ST_MMUL:  cmd.op = OP_MMUL;
			ST_MFIN:  cmd.op = OP_MFIN;
			ST_DONE:  cmd.op = out_free ? OP_OUT : OP_NOP;
			default:  cmd.op = OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			axis_q     <= '0;
			k_q        <= '0;
			j_q        <= 1'b0;
			rotor_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && !done_fire)
				m_tvalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						axis_q  <= '0;
						state_q <= ST_RATE;
					end
				end
				ST_RATE: state_q <= ST_ERR;
				ST_ERR: begin
					k_q     <= '0;
					j_q     <= 1'b0;
					state_q <= ST_COEF;
				end
				ST_COEF: begin
					if (int'(j_q) == NCH - 1) begin
						j_q <= 1'b0;
						if (k_q == 2'd2)
							state_q <= ST_DRAIN;
						else
							k_q <= k_q + 2'd1;
					end else begin
						j_q <= 1'b1;
					end
				end
				ST_DRAIN: state_q <= ST_FIN;
				ST_FIN: begin
					if (axis_q == AX_YAW) begin
						rotor_q <= ROT_FRONT;
						state_q <= ST_MSUM;
					end else begin
						axis_q  <= axis_q + 2'd1;
						state_q <= ST_RATE;
					end
				end
				ST_MSUM: begin
					j_q     <= 1'b0;
					state_q <= ST_MMUL;
				end
				ST_MMUL: begin
					if (j_q) begin
						j_q     <= 1'b0;
						state_q <= ST_MDRAIN;
					end else begin
						j_q <= 1'b1;
					end
				end
				ST_MDRAIN: state_q <= ST_MFIN;
				ST_MFIN: begin
					if (rotor_q == ROT_LEFT) begin
						state_q <= ST_DONE;
					end else begin
						rotor_q <= rotor_q + 2'd1;
						state_q <= ST_MSUM;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == ST_RATE && axis_q == AX_ROLL)
		else $error("accepted transfer did not start the roll axis");
	a_valid_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q) == ST_DONE)
		else $error("result raised outside completion");
	a_done_releases: assert property (@(posedge clk) disable iff (!arst_n)
		done_fire |=> state_q == ST_IDLE && m_tvalid_q)
		else $error("completion did not present result");
	a_counters: assert property (@(posedge clk) disable iff (!arst_n)
		axis_q != 2'd3 && k_q != 2'd3)
		else $error("axis or coefficient counter out of range");
`endif

endmodule

/* verif/tb.sv */
// Self-checking testbench for the rate PID quad mixer core: stream transfers checked against a local predictor.
`timescale 1ns / 1ps
module tb;
	import rpqm_pkg::*;

	localparam int CW = COEF_W_DEF;
	localparam int DW = DATA_W_DEF;

	localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

	typedef struct packed {
		logic [THR_W-1:0] thrust;
		logic [REF_W-1:0] yaw_ref;
		logic [REF_W-1:0] pitch_ref;
		logic [REF_W-1:0] roll_ref;
		logic [ANG_W-1:0] yaw_ang;
		logic [ANG_W-1:0] pitch_ang;
		logic [ANG_W-1:0] roll_ang;
	} attitude_t;

	typedef struct packed {
		logic [SPD_W-1:0] left;
		logic [SPD_W-1:0] back;
		logic [SPD_W-1:0] right;
		logic [SPD_W-1:0] front;
	} rotors_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [OUT_W-1:0] m_tdata;
	logic cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	rate_pid_quad_mixer_core dut (.*);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	// predictor state
	logic [COEF_REG_W-1:0] coef_reg [3]; // indexed by axis: roll, pitch, yaw
	longint isp, gain, lim_hi, lim_lo;
	longint prev_ang [3];
	longint err_hist [6];
	longint pid_out [3];

	attitude_t pending_in [$];
	rotors_t expected_speeds [$];
	int idle_in_pct, idle_out_pct;
	int errors = 0;
	int results_seen = 0;

	function automatic longint sat(longint v, int w);
		longint hi, lo;
		hi = (longint'(1) <<< (w - 1)) - 1;
		lo = -hi - 1;
		return v > hi ? hi : (v < lo ? lo : v);
	endfunction

	function automatic longint fdiv(longint v, longint d);
		if (v >= 0)
			return v / d;
		return -((-v + d - 1) / d);
	endfunction

	function automatic longint pid_axis(int ax, longint ang, longint rref);
		longint rate, e0, e1, e2, acc_hi, acc_lo, q, eh, raw;
		longint e [3];
		rate = (ang - prev_ang[ax]) * isp * 2;
		prev_ang[ax] = ang;
		e0 = sat(rref - rate, DW);
		e1 = err_hist[2*ax];
		e2 = err_hist[2*ax+1];
		e[0] = e0; e[1] = e1; e[2] = e2;
		acc_hi = pid_out[ax];
		acc_lo = 0;
		for (int k = 0; k < 3; k++) begin
			q = longint'($signed(coef_reg[ax][k*CW +: CW]));
			eh = fdiv(e[k], 256);
			acc_hi += q * eh;
			acc_lo += q * (e[k] - eh * 256);
		end
		raw = acc_hi + fdiv(acc_lo + 128, 256);
		if (lim_hi != 0) begin
			if (raw > lim_hi) raw = lim_hi;
			if (raw < lim_lo) raw = lim_lo;
		end
		raw = sat(raw, DW);
		err_hist[2*ax+1] = e1;
		err_hist[2*ax] = e0;
		pid_out[ax] = raw;
		return raw;
	endfunction

	function automatic logic [SPD_W-1:0] scale_speed(longint s2);
		longint bound, p;
		bound = longint'(1) <<< 46;
		if (gain == 0)
			return '0;
		if (s2 > bound) s2 = bound;
		if (s2 < -bound) s2 = -bound;
		p = sat(fdiv(s2 * gain + 256, 512), 32);
		return p[SPD_W-1:0];
	endfunction

	function automatic rotors_t predict_speeds(attitude_t a);
		longint p, r, y, t2;
		rotors_t o;
		t2 = longint'(a.thrust) * 2;
		p = pid_axis(AX_PITCH, longint'($signed(a.pitch_ang)), longint'($signed(a.pitch_ref)));
		r = pid_axis(AX_ROLL, longint'($signed(a.roll_ang)), longint'($signed(a.roll_ref)));
		y = pid_axis(AX_YAW, longint'($signed(a.yaw_ang)), longint'($signed(a.yaw_ref)));
		o.front = scale_speed(t2 - p - r - 2*y);
		o.right = scale_speed(t2 + p - r + 2*y);
		o.back = scale_speed(t2 + p + r - 2*y);
		o.left = scale_speed(t2 - p + r + 2*y);
		return o;
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || s_tready) begin
				if (pending_in.size() > 0 && $urandom_range(99) >= idle_in_pct) begin
					s_tvalid <= 1;
					s_tdata <= pending_in[0];
					expected_speeds.insert(expected_speeds.size(),
						predict_speeds(pending_in.pop_front()));
				end else begin
					s_tvalid <= 0;
				end
			end
			m_tready <= ($urandom_range(99) >= idle_out_pct);
		end
	end

	// monitor
	always @(posedge clk) begin
		rotors_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			results_seen++;
			if (expected_speeds.size() == 0) begin
				$error("result transfer with nothing expected: %h", m_tdata);
				errors++;
			end else begin
				want = expected_speeds.pop_front();
				if (got.front !== want.front) begin
					$error("rotor_front_speed exp %h got %h", want.front, got.front);
					errors++;
				end
				if (got.right !== want.right) begin
					$error("rotor_right_speed exp %h got %h", want.right, got.right);
					errors++;
				end
				if (got.back !== want.back) begin
					$error("rotor_back_speed exp %h got %h", want.back, got.back);
					errors++;
				end
				if (got.left !== want.left) begin
					$error("rotor_left_speed exp %h got %h", want.left, got.left);
					errors++;
				end
			end
		end
	end

	task automatic queue_item(attitude_t a);
		pending_in.insert(pending_in.size(), a);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		case (idx)
			REG_PITCH_COEF: coef_reg[AX_PITCH] = val;
			REG_ROLL_COEF: coef_reg[AX_ROLL] = val;
			REG_YAW_COEF: coef_reg[AX_YAW] = val;
			REG_ISP: isp = val[ISP_W-1:0];
			REG_GAIN: gain = val[GAIN_W-1:0];
			REG_LIM_HI: lim_hi = longint'($signed(val[LIM_W-1:0]));
			REG_LIM_LO: lim_lo = longint'($signed(val[LIM_W-1:0]));
			default: ;
		endcase
	endtask

	task automatic drain();
		while (pending_in.size() > 0 || expected_speeds.size() > 0 || s_tvalid)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	function automatic logic [CW-1:0] rand_coef();
		case ($urandom_range(5))
			0: return {1'b0, {(CW-1){1'b1}}};
			1: return {1'b1, {(CW-1){1'b0}}};
			2: return '0;
			default: return CW'($urandom_range(1023) - 512);
		endcase
	endfunction

	function automatic logic [CW*3-1:0] rand_coefs();
		return {rand_coef(), rand_coef(), rand_coef()};
	endfunction

	function automatic logic [ANG_W-1:0] rand_ang();
		int a;
		a = $urandom_range(46080) - 23040;
		if ($urandom_range(9) == 0) a = $urandom_range(1) ? 23040 : -23040;
		if ($urandom_range(9) < 5) a = $urandom_range(200) - 100;
		return ANG_W'(a);
	endfunction

	function automatic logic [REF_W-1:0] rand_ref();
		case ($urandom_range(5))
			0: return {1'b0, {(REF_W-1){1'b1}}};
			1: return {1'b1, {(REF_W-1){1'b0}}};
			2: return REF_W'($urandom());
			default: return REF_W'($urandom_range(8000) - 4000);
		endcase
	endfunction

	function automatic attitude_t rand_item();
		attitude_t a;
		a.roll_ang = rand_ang();
		a.pitch_ang = rand_ang();
		a.yaw_ang = rand_ang();
		a.roll_ref = rand_ref();
		a.pitch_ref = rand_ref();
		a.yaw_ref = rand_ref();
		a.thrust = $urandom_range(3) == 0 ? THR_W'($urandom()) : THR_W'($urandom_range(65535));
		return a;
	endfunction

	function automatic attitude_t make_item(int ang, int rref, int thr);
		attitude_t a;
		a.roll_ang = ANG_W'(ang); a.pitch_ang = ANG_W'(-ang); a.yaw_ang = ANG_W'(ang);
		a.roll_ref = REF_W'(rref); a.pitch_ref = REF_W'(rref); a.yaw_ref = REF_W'(-rref);
		a.thrust = THR_W'(thr);
		return a;
	endfunction

	initial begin
		int phase;
		coef_reg[0] = '0; coef_reg[1] = '0; coef_reg[2] = '0;
		isp = 100; gain = 256; lim_hi = 0; lim_lo = 0;
		for (int i = 0; i < 3; i++) begin prev_ang[i] = 0; pid_out[i] = 0; end
		for (int i = 0; i < 6; i++) err_hist[i] = 0;
		idle_in_pct = 37; idle_out_pct = 65;
		repeat (6) @(posedge clk);
		arst_n <= 1;

		// directed: defaults first (zero coefficients), then extremes
		queue_item(make_item(23040, 0, 1000));
		queue_item(make_item(-23040, 8388607, 16777215));
		drain();
		write_reg(REG_PITCH_COEF, {21'sd256, -21'sd128, 21'sd512});
		write_reg(REG_ROLL_COEF, {{1'b0, {20{1'b1}}}, {1'b1, 20'd0}, 21'd300});
		write_reg(REG_YAW_COEF, {21'sd50, 21'sd0, -21'sd700});
		write_reg(REG_NONE, {CFG_W{1'b1}});
		queue_item(make_item(0, -8388608, 0));
		queue_item(make_item(23040, 8388607, 16777215));
		queue_item(make_item(-23040, -8388608, 16777215));
		queue_item(make_item(-1, 1, 1));
		drain();
		write_reg(REG_ISP, '0);
		write_reg(REG_GAIN, '0);
		queue_item(make_item(100, 500, 40000));
		queue_item(make_item(-100, -500, 40000));
		drain();
		write_reg(REG_ISP, CFG_W'(16'hFFFF));
		write_reg(REG_GAIN, CFG_W'(16'hFFFF));
		write_reg(REG_LIM_HI, CFG_W'(32'sd20000));
		write_reg(REG_LIM_LO, CFG_W'(-32'sd20000));
		for (int i = 0; i < 5; i++) queue_item(rand_item());
		queue_item(make_item(23040, 8388607, 16777215));
		queue_item(make_item(-23040, -8388608, 16777215));
		drain();
		// lower bound above upper bound
		write_reg(REG_LIM_HI, CFG_W'(32'sd100));
		write_reg(REG_LIM_LO, CFG_W'(32'sd5000));
		for (int i = 0; i < 4; i++) queue_item(rand_item());
		drain();
		write_reg(REG_LIM_HI, CFG_W'(32'h7FFFFFFF));
		write_reg(REG_LIM_LO, CFG_W'(32'h80000000));
		for (int i = 0; i < 3; i++) queue_item(rand_item());
		drain();

		// random phases with fresh settings
		for (phase = 0; phase < 12; phase++) begin
			if (phase == 4) begin idle_in_pct = 65; idle_out_pct = 37; end
			if (phase == 8) begin idle_in_pct = 0; idle_out_pct = 0; end
			write_reg(REG_PITCH_COEF, CFG_W'(rand_coefs()));
			write_reg(REG_ROLL_COEF, CFG_W'(rand_coefs()));
			write_reg(REG_YAW_COEF, CFG_W'(rand_coefs()));
			write_reg(REG_ISP, $urandom_range(3) == 0 ? CFG_W'($urandom())
				: CFG_W'($urandom_range(1, 400)));
			write_reg(REG_GAIN, $urandom_range(3) == 0 ? CFG_W'($urandom())
				: CFG_W'($urandom_range(512)));
			if ($urandom_range(1)) begin
				write_reg(REG_LIM_HI, '0);
				write_reg(REG_LIM_LO, CFG_W'($urandom()));
			end else begin
				write_reg(REG_LIM_HI, CFG_W'($urandom_range(1, 2000000)));
				write_reg(REG_LIM_LO, CFG_W'(-$urandom_range(2000000)));
			end
			for (int i = 0; i < 78; i++) queue_item(rand_item());
			drain();
		end

		$display("covered %0d result transfers over directed extremes and 12 random settings",
			results_seen);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#20ms;
		$display("[FAIL] regression broken");
		$finish;
	end
endmodule
